[hdl/dqp_pkg.sv]
package dqp_pkg;

    localparam logic [7:0] CharZero = 8'h30;
    localparam logic [7:0] CharNine = 8'h39;
    localparam logic [7:0] CharDot  = 8'h2E;

    // octet accumulator saturates at this value
    localparam logic [8:0] OctetLimit = 9'd256;
    localparam logic [1:0] LastOctet  = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       string_start;
    } t_char;

    typedef struct packed {
        logic [31:0] address;
        logic        parse_ok;
    } t_result;

    typedef struct packed {
        logic [1:0]  octet_index;
        logic [8:0]  octet_accumulator;
        logic [23:0] finished_octets;
        logic        parse_active;
    } t_state;

endpackage

[hdl/dqp_if.sv]
interface dqp_char_if;
    logic                 valid;
    logic                 ready;
    dqp_pkg::t_char       data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dqp_result_if;
    logic                 valid;
    logic                 ready;
    dqp_pkg::t_result     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/dotted_quad_ipv4_parser.sv]
// Dotted-decimal IPv4 parser: takes one ASCII character per transaction on
// i_char, with string_start set on the first character of each string, and
// gives one transaction on o_result per string once it ends, either the
// address (first octet in bits 31 to 24) with parse_ok set, or zero with
// parse_ok clear on a bad character or an octet above 255. Characters before
// the first start, or after a string has given its result, are taken and
// dropped; a string cut short by a new start gives no result. One character
// is taken every cycle unless the input register holds back; a result goes
// into the result register driving o_result once its last character has left
// the input register. The input register only holds back when it carries a
// result-producing character while the output register is still full and
// stalled, so one more character is always taken behind a waiting result.
module dotted_quad_ipv4_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    dqp_char_if.sink            i_char,
    dqp_result_if.source        o_result
);

    // input register
    logic                r_in_valid;
    dqp_pkg::t_char      r_in_data;

    // parser state
    dqp_pkg::t_state     r_state;
    dqp_pkg::t_state     n_state;

    // result register
    logic                r_out_valid;
    dqp_pkg::t_result    r_out_data;

    logic                step_emit;
    dqp_pkg::t_result    step_result;
    logic                out_free;
    logic                in_advance;
    logic                in_take;

    dqp_step u_step (
        .i_state  (r_state),
        .i_char   (r_in_data),
        .o_state  (n_state),
        .o_emit   (step_emit),
        .o_result (step_result)
    );

    // the output slot is free when empty or being read this cycle
    assign out_free   = !r_out_valid || o_result.ready;
    // characters that give no result never wait for the output side
    assign in_advance = r_in_valid && (!step_emit || out_free);
    assign i_char.ready = i_rst_n && (!r_in_valid || in_advance);
    assign in_take    = i_char.valid && i_char.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (in_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_char.data;
        end
    end

    // state moves on once per processed character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_advance && step_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_advance && step_emit) begin
            r_out_data <= step_result;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_data;

endmodule

[hdl/dqp_step.sv]
module dqp_step (
    input  dqp_pkg::t_state  i_state,
    input  dqp_pkg::t_char   i_char,
    output dqp_pkg::t_state  o_state,
    output logic             o_emit,
    output dqp_pkg::t_result o_result
);

    dqp_pkg::t_state s;
    logic [11:0]     times_ten;
    logic [11:0]     digit_sum;
    logic            is_digit;

    always_comb begin
        s = i_state;
        if (i_char.string_start) begin
            s = '0;
            s.parse_active = 1'b1;
        end

        is_digit  = i_char.char_code inside {[dqp_pkg::CharZero:dqp_pkg::CharNine]};
        // acc * 10 as two shifts
        times_ten = {s.octet_accumulator, 3'b000} + {2'b00, s.octet_accumulator, 1'b0};
        digit_sum = times_ten + {8'd0, i_char.char_code[3:0]};

        o_state  = s;
        o_emit   = 1'b0;
        o_result = '0;

        if (s.parse_active) begin
            if (is_digit) begin
                o_state.octet_accumulator = (digit_sum >= {3'b000, dqp_pkg::OctetLimit})
                                          ? dqp_pkg::OctetLimit : digit_sum[8:0];
            end else if (s.octet_index != dqp_pkg::LastOctet
                         && i_char.char_code == dqp_pkg::CharDot) begin
                if (s.octet_accumulator[8]) begin
                    o_emit = 1'b1;
                end else begin
                    o_state.finished_octets   = {s.finished_octets[15:0],
                                                 s.octet_accumulator[7:0]};
                    o_state.octet_index       = s.octet_index + 2'd1;
                    o_state.octet_accumulator = '0;
                end
            end else if (s.octet_index == dqp_pkg::LastOctet) begin
                o_emit = 1'b1;
                if (!s.octet_accumulator[8]) begin
                    o_result.address  = {s.finished_octets, s.octet_accumulator[7:0]};
                    o_result.parse_ok = 1'b1;
                end
            end else begin
                // bad character in the first three octets
                o_emit = 1'b1;
            end
        end

        if (o_emit) begin
            o_state.parse_active = 1'b0;
        end
    end

endmodule

[hdl/dqp_checker.sv]
module dqp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_char_valid,
    input logic        i_char_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_address,
    input logic        i_out_parse_ok
);

    // a failure always carries a zero address
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_parse_ok |-> i_out_address == 32'd0)
        else $error("failure result with non-zero address");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_address)
                                        && $stable(i_out_parse_ok))
        else $error("stalled result changed");

    // a fresh result follows a taken character
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_char_valid && i_char_ready, 2))
        else $error("result without a preceding character");

    // input is never refused while output side is empty
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !i_out_valid && $past(!i_out_valid) |-> i_char_ready)
        else $error("input stalled with empty output");

endmodule

bind dotted_quad_ipv4_parser dqp_checker u_dqp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_char_valid   (i_char.valid),
    .i_char_ready   (i_char.ready),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_out_address  (o_result.data.address),
    .i_out_parse_ok (o_result.data.parse_ok)
);

[tb/dotted_quad_ipv4_parser_tb.sv]
module dotted_quad_ipv4_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // decimal weight of each digit, wide enough for the saturated accumulator times ten
    localparam logic [11:0] Radix   = 12'd10;
    localparam logic [7:0]  CharNul = 8'h00;

    // characters per idling phase of the random part
    localparam int PhaseChars = 450;

    // mirrors the parser: follows every accepted character and queues the address it should give
    class address_scoreboard;
        dqp_pkg::t_result expected_q[$];
        int          mismatches;
        logic [1:0]  octet_idx;
        logic [8:0]  octet_acc;
        logic [23:0] done_octets;
        logic        busy;

        function new();
            mismatches  = 0;
            octet_idx   = '0;
            octet_acc   = '0;
            done_octets = '0;
            busy        = 1'b0;
        endfunction

        function void close_string(logic [31:0] addr, logic ok);
            dqp_pkg::t_result r;
            r.address  = addr;
            r.parse_ok = ok;
            expected_q.push_back(r);
            busy = 1'b0;
        endfunction

        function void take_char(dqp_pkg::t_char ch);
            logic [11:0] grown;
            // a start drops any unfinished string and parses this character afresh
            if (ch.string_start) begin
                octet_idx   = '0;
                octet_acc   = '0;
                done_octets = '0;
                busy        = 1'b1;
            end
            if (!busy) return;
            if (ch.char_code >= dqp_pkg::CharZero && ch.char_code <= dqp_pkg::CharNine) begin
                grown = {3'd0, octet_acc} * Radix
                      + {4'd0, ch.char_code - dqp_pkg::CharZero};
                octet_acc = (grown >= {3'd0, dqp_pkg::OctetLimit})
                          ? dqp_pkg::OctetLimit : grown[8:0];
            end else if (octet_idx != dqp_pkg::LastOctet && ch.char_code == dqp_pkg::CharDot) begin
                if (octet_acc >= dqp_pkg::OctetLimit) begin
                    close_string('0, 1'b0);
                end else begin
                    done_octets = {done_octets[15:0], octet_acc[7:0]};
                    octet_idx   = octet_idx + 2'd1;
                    octet_acc   = '0;
                end
            end else if (octet_idx == dqp_pkg::LastOctet && octet_acc < dqp_pkg::OctetLimit) begin
                close_string({done_octets, octet_acc[7:0]}, 1'b1);
            end else begin
                close_string('0, 1'b0);
            end
        endfunction

        function void check_address(dqp_pkg::t_result got);
            dqp_pkg::t_result want;
            if (expected_q.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got address %h parse_ok %b",
                         $time, got.address, got.parse_ok);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.address !== want.address) begin
                $display("%0t ns: address expected %h, got %h", $time, want.address, got.address);
                mismatches++;
            end
            if (got.parse_ok !== want.parse_ok) begin
                $display("%0t ns: parse_ok expected %b, got %b", $time, want.parse_ok,
                         got.parse_ok);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    dqp_char_if   char_bus();
    dqp_result_if result_bus();

    dotted_quad_ipv4_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .o_result(result_bus)
    );

    address_scoreboard board = new();

    // idling odds in percent, changed from phase to phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int sent_count     = 0;

    // characters of the string being built, sent with a start on the first one
    logic [7:0] text_q[$];

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver side: random stalls on the result channel
    always @(posedge i_clk) begin
        result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // both channels watched at the same edge; a character is noted before any result is checked
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (char_bus.valid && char_bus.ready) board.take_char(char_bus.data);
            if (result_bus.valid && result_bus.ready) board.check_address(result_bus.data);
        end
    end

    // one character transaction, after a random number of idle cycles
    task automatic send_char(input logic [7:0] code, input logic first);
        while ($urandom_range(99) < send_idle_pct) begin
            char_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        char_bus.valid             <= 1'b1;
        char_bus.data.char_code    <= code;
        char_bus.data.string_start <= first;
        @(posedge i_clk);
        while (!char_bus.ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == 0);
        text_q.delete();
    endtask

    // one octet of digits; oversize ones go past 255, sometimes as a long run to test saturation
    task automatic add_octet(input bit oversize);
        int pick;
        pick = $urandom_range(99);
        if (oversize) begin
            if (pick < 30) begin
                repeat ($urandom_range(12, 4))
                    text_q.push_back(dqp_pkg::CharNine - 8'($urandom_range(8)));
            end else begin
                push_str($sformatf("%0d", $urandom_range(99999, 256)));
            end
        end else if (pick < 8) begin
            // empty octet, reads as zero
        end else if (pick < 20) begin
            push_str($sformatf("%03d", $urandom_range(255)));
        end else if (pick < 30) begin
            push_str(($urandom_range(1) != 0) ? "255" : "0");
        end else begin
            push_str($sformatf("%0d", $urandom_range(255)));
        end
    endtask

    // mostly well-formed addresses with random content, the rest broken or plain noise
    task automatic send_random_string();
        int         kind;
        int         big_at;
        int         cut;
        logic [7:0] term;
        kind   = $urandom_range(99);
        big_at = $urandom_range(3);
        if (kind >= 95) begin
            // stray bytes without a start: dropped when idle, parsed after a cut-short string
            repeat ($urandom_range(6, 1)) send_char(8'($urandom_range(255)), 1'b0);
            return;
        end
        for (int i = 0; i < 4; i++) begin
            if (i != 0) text_q.push_back(dqp_pkg::CharDot);
            add_octet(kind >= 88 && i == big_at);
        end
        // any non-digit ends the last octet, a dot included
        if ($urandom_range(3) == 0) begin
            term = CharNul;
        end else begin
            do term = 8'($urandom_range(255));
            while (term >= dqp_pkg::CharZero && term <= dqp_pkg::CharNine);
        end
        text_q.push_back(term);
        if (kind >= 70 && kind < 80) begin
            // one character swapped for any byte
            text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
        end else if (kind >= 80 && kind < 88) begin
            // cut short: no terminator, the next start drops it
            cut = $urandom_range(text_q.size() - 1, 1);
            while (text_q.size() > cut) void'(text_q.pop_back());
        end
        send_text();
    endtask

    initial begin
        int target;
        char_bus.valid             <= 1'b0;
        char_bus.data.char_code    <= CharNul;
        char_bus.data.string_start <= 1'b0;
        i_rst_n                    <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, no idling
        // byte before any start is ignored
        send_char("x", 1'b0);
        // extremes and an empty octet, ended by the top byte value
        push_str("255.0..7");
        text_q.push_back(8'hFF);
        send_text();
        // octet too large before a dot, then a byte after the result is ignored
        push_str("3000.");
        send_text();
        send_char("1", 1'b0);
        // bad character in the first octet
        push_str("1a");
        send_text();
        // start while parsing drops the first string; four dots give an all-zero address
        push_str("12");
        send_text();
        push_str("....");
        send_text();
        // last octet too large, ended by a nul
        push_str("1.2.3.256");
        text_q.push_back(CharNul);
        send_text();

        // random part in four idling phases
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 72;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 72;
                end
                default: begin
                    send_idle_pct  = 27;
                    recv_stall_pct = 27;
                end
            endcase
            target = sent_count + PhaseChars;
            while (sent_count < target) send_random_string();
        end

        // drain: let the last character be noted, wait for every queued address,
        // then keep watching for anything stray
        char_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (board.mismatches == 0) begin
            $display("** dotted_quad_ipv4_parser: PASSED **");
        end else begin
            $display("** dotted_quad_ipv4_parser: FAILED **");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #20ms;
        $display("** dotted_quad_ipv4_parser: FAILED **");
        $finish;
    end

endmodule

[dotted_quad_ipv4_parser.f]
hdl/dqp_pkg.sv
hdl/dqp_if.sv
hdl/dqp_step.sv
hdl/dotted_quad_ipv4_parser.sv
hdl/dqp_checker.sv
tb/dotted_quad_ipv4_parser_tb.sv
